// ===== hdl/psfc_pkg.sv =====
package psfc_pkg;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S24 = 3'd2;
  localparam logic [2:0] FMT_S32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;

  localparam logic CMD_TO_FLOAT = 1'b0;
  localparam logic CMD_TO_PCM   = 1'b1;

  localparam logic [1:0] PATH_DIRECT = 2'd0;
  localparam logic [1:0] PATH_I2F    = 2'd1;
  localparam logic [1:0] PATH_F2I    = 2'd2;

  // Fixed point used for the float-to-PCM sum: 32 integer bits, 55 fraction
  // bits and a sticky bit in the LSB.
  localparam int FIX_W  = 88;
  localparam int FRAC_W = 56;
  localparam int PROD_W = 56;

  localparam logic [FIX_W-1:0] C_HALF    = FIX_W'(1) << (FRAC_W - 1);
  localparam logic [FIX_W-1:0] C_128_5   = FIX_W'(257) << (FRAC_W - 1);
  localparam logic [FIX_W-1:0] C_127_5   = FIX_W'(255) << (FRAC_W - 1);

  typedef struct packed {
    logic [1:0]  path;
    logic [31:0] word;
    logic        sign;
    logic [31:0] mag;
    logic [7:0]  ebase;
    logic        neg;
    logic [1:0]  fmt;
    logic [23:0] mant;
    logic [5:0]  e6;
  } dec_t;

  typedef struct packed {
    logic [1:0]        path;
    logic [31:0]       word;
    logic              sign;
    logic              zero;
    logic [31:0]       norm;
    logic [7:0]        expo;
    logic              neg;
    logic [1:0]        fmt;
    logic [5:0]        e6;
    logic [PROD_W-1:0] prod;
  } mul_t;

  typedef struct packed {
    logic              f2i;
    logic [31:0]       word;
    logic              neg;
    logic [1:0]        fmt;
    logic [5:0]        e6;
    logic [PROD_W-1:0] prod;
  } rnd_t;

  typedef struct packed {
    logic             f2i;
    logic [31:0]      word;
    logic             neg;
    logic [1:0]       fmt;
    logic [FIX_W-1:0] fx;
  } aln_t;

  typedef struct packed {
    logic             f2i;
    logic [31:0]      word;
    logic             neg;
    logic [1:0]       fmt;
    logic [FIX_W-1:0] s;
    logic [6:0]       li;
  } sum_t;

  function automatic logic [4:0] lz32(input logic [31:0] x);
    logic [31:0] v;
    logic [4:0]  n;
    v = x;
    n = '0;
    if (v[31:16] == 16'd0) begin n[4] = 1'b1; v = v << 16; end
    if (v[31:24] == 8'd0) begin n[3] = 1'b1; v = v << 8; end
    if (v[31:28] == 4'd0) begin n[2] = 1'b1; v = v << 4; end
    if (v[31:30] == 2'd0) begin n[1] = 1'b1; v = v << 2; end
    if (v[31] == 1'b0) begin n[0] = 1'b1; end
    return n;
  endfunction

  // Scale factor of the float-to-PCM product.
  function automatic logic [31:0] kconst(input logic [1:0] fmt, input logic neg);
    logic [31:0] k;
    unique case (fmt)
      FMT_U8[1:0]:  k = 32'd127;
      FMT_S16[1:0]: k = neg ? 32'd32768 : 32'd32767;
      FMT_S24[1:0]: k = neg ? 32'd8388608 : 32'd8388607;
      default:      k = neg ? 32'd2147483648 : 32'd2147483647;
    endcase
    return k;
  endfunction

  // Highest bit the product can reach: bit length of the scale factor plus 23.
  function automatic logic [5:0] tpos(input logic [1:0] fmt, input logic neg);
    logic [5:0] t;
    unique case (fmt)
      FMT_U8[1:0]:  t = 6'd30;
      FMT_S16[1:0]: t = neg ? 6'd39 : 6'd38;
      FMT_S24[1:0]: t = neg ? 6'd47 : 6'd46;
      default:      t = neg ? 6'd55 : 6'd54;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/psfc_decode.sv =====
module psfc_decode (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0]          fmt,
  input  logic                cmd,
  input  logic [31:0]         data_word,
  output psfc_pkg::dec_t      dec_r
);
  import psfc_pkg::*;

  dec_t        dec_nxt;
  logic        nan;
  logic        big;
  logic [32:0] sv;

  always_comb begin
    nan = (data_word[30:23] == 8'hFF) && (data_word[22:0] != 23'd0);
    big = data_word[30:0] > 31'h3F800000;

    case (fmt[1:0])
      FMT_U8[1:0]:  sv = {25'd0, data_word[7:0]} - 33'd128;
      FMT_S16[1:0]: sv = {{17{data_word[15]}}, data_word[15:0]};
      FMT_S24[1:0]: sv = {{9{data_word[23]}}, data_word[23:0]};
      default:      sv = {data_word[31], data_word};
    endcase

    dec_nxt      = '0;
    dec_nxt.fmt  = fmt[1:0];
    dec_nxt.sign = sv[32];
    dec_nxt.mag  = sv[32] ? 32'(-sv) : sv[31:0];
    case (fmt[1:0])
      FMT_U8[1:0]:  dec_nxt.ebase = 8'd151;
      FMT_S16[1:0]: dec_nxt.ebase = 8'd143;
      FMT_S24[1:0]: dec_nxt.ebase = 8'd135;
      default:      dec_nxt.ebase = 8'd127;
    endcase

    // Clamp to [-1,1] and map NaN to +0; values too small to reach any output bit
    // are flushed to zero, nonzero ones keeping their sign for the branch choice.
    if (nan) begin
      dec_nxt.neg  = 1'b0;
      dec_nxt.mant = '0;
      dec_nxt.e6   = '0;
    end else if (big) begin
      dec_nxt.neg  = data_word[31];
      dec_nxt.mant = 24'h800000;
      dec_nxt.e6   = 6'd63;
    end else if (data_word[30:23] < 8'd64) begin
      dec_nxt.neg  = data_word[31] && (data_word[30:0] != 31'd0);
      dec_nxt.mant = '0;
      dec_nxt.e6   = '0;
    end else begin
      dec_nxt.neg  = data_word[31];
      dec_nxt.mant = {1'b1, data_word[22:0]};
      dec_nxt.e6   = data_word[28:23];
    end

    if (fmt == FMT_F32) begin
      dec_nxt.path = PATH_DIRECT;
      if (nan) begin
        dec_nxt.word = data_word;
      end else if (big) begin
        dec_nxt.word = {data_word[31], 31'h3F800000};
      end else begin
        dec_nxt.word = data_word;
      end
    end else if (fmt > FMT_F32) begin
      dec_nxt.path = PATH_DIRECT;
      dec_nxt.word = '0;
    end else if (cmd == CMD_TO_FLOAT) begin
      dec_nxt.path = PATH_I2F;
    end else begin
      dec_nxt.path = PATH_F2I;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

// ===== hdl/psfc_mul.sv =====
module psfc_mul (
  input  logic                clk,
  input  logic                en_mul,
  input  logic                en_rnd,
  input  psfc_pkg::dec_t      dec_r,
  output psfc_pkg::rnd_t      rnd_r
);
  import psfc_pkg::*;

  mul_t              mul_r;
  mul_t              mul_nxt;
  rnd_t              rnd_nxt;
  logic [4:0]        lz;
  logic [5:0]        tp;
  logic [6:0]        bl;
  logic [5:0]        dsh;
  logic [PROD_W-1:0] pmask;
  logic [PROD_W-1:0] phalf;
  logic [PROD_W-1:0] prem;
  logic              pup;
  logic [23:0]       keep;
  logic              rup;
  logic [24:0]       m25;
  logic [7:0]        efin;

  // Stage 2: scale product for float-to-PCM, normalize for PCM-to-float.
  always_comb begin
    lz            = lz32(dec_r.mag);
    mul_nxt.path  = dec_r.path;
    mul_nxt.word  = dec_r.word;
    mul_nxt.sign  = dec_r.sign;
    mul_nxt.zero  = (dec_r.mag == 32'd0);
    mul_nxt.norm  = dec_r.mag << lz;
    mul_nxt.expo  = dec_r.ebase - {3'd0, lz};
    mul_nxt.neg   = dec_r.neg;
    mul_nxt.fmt   = dec_r.fmt;
    mul_nxt.e6    = dec_r.e6;
    mul_nxt.prod  = PROD_W'(dec_r.mant) * PROD_W'(kconst(dec_r.fmt, dec_r.neg));
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      mul_r <= mul_nxt;
    end
  end

  // Stage 3: round the product to float or double precision, and finish the
  // PCM-to-float result.
  always_comb begin
    tp    = tpos(mul_r.fmt, mul_r.neg);
    bl    = mul_r.prod[tp] ? {1'b0, tp} + 7'd1 : {1'b0, tp};
    dsh   = 6'(bl - ((mul_r.fmt == FMT_S32[1:0]) ? 7'd53 : 7'd24));
    pmask = (PROD_W'(1) << dsh) - PROD_W'(1);
    phalf = PROD_W'(1) << (dsh - 6'd1);
    prem  = mul_r.prod & pmask;
    pup   = (prem > phalf) || ((prem == phalf) && mul_r.prod[dsh]);

    keep  = mul_r.norm[31:8];
    rup   = mul_r.norm[7] && ((mul_r.norm[6:0] != 7'd0) || keep[0]);
    m25   = {1'b0, keep} + {24'd0, rup};
    efin  = mul_r.expo + {7'd0, m25[24]};

    rnd_nxt.f2i  = (mul_r.path == PATH_F2I);
    rnd_nxt.neg  = mul_r.neg;
    rnd_nxt.fmt  = mul_r.fmt;
    rnd_nxt.e6   = mul_r.e6;
    rnd_nxt.prod = (mul_r.prod & ~pmask) + (pup ? (PROD_W'(1) << dsh) : PROD_W'(0));
    if (mul_r.path == PATH_I2F) begin
      if (mul_r.zero) begin
        rnd_nxt.word = '0;
      end else begin
        rnd_nxt.word = {mul_r.sign, efin, m25[24] ? 23'd0 : m25[22:0]};
      end
    end else begin
      rnd_nxt.word = mul_r.word;
    end
  end

  always_ff @(posedge clk) begin
    if (en_rnd) begin
      rnd_r <= rnd_nxt;
    end
  end

endmodule

// ===== hdl/psfc_align.sv =====
module psfc_align (
  input  logic                clk,
  input  logic                en_aln,
  input  logic                en_sum,
  input  psfc_pkg::rnd_t      rnd_r,
  output psfc_pkg::sum_t      sum_r
);
  import psfc_pkg::*;

  aln_t             aln_r;
  aln_t             aln_nxt;
  sum_t             sum_nxt;
  logic [119:0]     yw;
  logic [FIX_W-1:0] sv;
  logic [4:0]       lz;

  // Stage 4: place the rounded product in the fixed-point frame.
  always_comb begin
    yw          = {64'd0, rnd_r.prod} << rnd_r.e6;
    aln_nxt.f2i  = rnd_r.f2i;
    aln_nxt.word = rnd_r.word;
    aln_nxt.neg  = rnd_r.neg;
    aln_nxt.fmt  = rnd_r.fmt;
    aln_nxt.fx   = {yw[117:31], yw[30] | (yw[29:0] != 30'd0)};
  end

  always_ff @(posedge clk) begin
    if (en_aln) begin
      aln_r <= aln_nxt;
    end
  end

  // Stage 5: add the offset and locate the leading bit of the sum.
  always_comb begin
    if (aln_r.fmt == FMT_U8[1:0]) begin
      sv = aln_r.neg ? (C_127_5 - aln_r.fx) : (C_128_5 + aln_r.fx);
    end else begin
      sv = C_HALF + aln_r.fx;
    end
    lz           = lz32(sv[FIX_W-1:FRAC_W]);
    sum_nxt.f2i  = aln_r.f2i;
    sum_nxt.word = aln_r.word;
    sum_nxt.neg  = aln_r.neg;
    sum_nxt.fmt  = aln_r.fmt;
    sum_nxt.s    = sv;
    // The sum is never below one half, so an empty integer part puts the
    // leading bit just under the binary point.
    if (sv[FIX_W-1:FRAC_W] == 32'd0) begin
      sum_nxt.li = 7'(FRAC_W - 1);
    end else begin
      sum_nxt.li = 7'(FIX_W - 1) - {2'd0, lz};
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== hdl/psfc_round.sv =====
module psfc_round (
  input  logic                clk,
  input  logic                en,
  input  psfc_pkg::sum_t      sum_r,
  output logic [31:0]         word_r
);
  import psfc_pkg::*;

  logic [31:0]      word_nxt;
  logic [6:0]       k;
  logic [FIX_W-1:0] mask;
  logic [FIX_W-1:0] half;
  logic [FIX_W-1:0] rem;
  logic             up;
  logic [FIX_W:0]   rsum;
  logic [32:0]      t;
  logic [31:0]      res;

  always_comb begin
    k    = sum_r.li - ((sum_r.fmt == FMT_S32[1:0]) ? 7'd52 : 7'd23);
    mask = (FIX_W'(1) << k) - FIX_W'(1);
    half = FIX_W'(1) << (k - 7'd1);
    rem  = sum_r.s & mask;
    up   = (rem > half) || ((rem == half) && sum_r.s[k]);
    rsum = {1'b0, sum_r.s & ~mask} + {1'b0, up ? (FIX_W'(1) << k) : FIX_W'(0)};
    t    = rsum[FIX_W:FRAC_W];

    case (sum_r.fmt)
      FMT_U8[1:0]: begin
        res = (t > 33'd255) ? 32'hFF : {24'd0, t[7:0]};
      end
      FMT_S16[1:0]: begin
        if (!sum_r.neg) begin
          res = (t > 33'd32767) ? 32'h7FFF : {16'd0, t[15:0]};
        end else begin
          res = (t >= 33'd32768) ? 32'h8000 : {16'd0, 16'd0 - t[15:0]};
        end
      end
      FMT_S24[1:0]: begin
        if (!sum_r.neg) begin
          res = (t > 33'd8388607) ? 32'h7FFFFF : {8'd0, t[23:0]};
        end else begin
          res = (t >= 33'd8388608) ? 32'h800000 : {8'd0, 24'd0 - t[23:0]};
        end
      end
      default: begin
        if (!sum_r.neg) begin
          res = (t > 33'd2147483647) ? 32'h7FFFFFFF : t[31:0];
        end else begin
          res = (t >= 33'd2147483648) ? 32'h80000000 : 32'd0 - t[31:0];
        end
      end
    endcase

    word_nxt = sum_r.f2i ? res : sum_r.word;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== hdl/pcm_sample_format_converter_top.sv =====
// Converts one audio sample per item between PCM and float32.
// Accepts one item per cycle while out_stall is low, through a six-stage
// pipeline whose stages each advance when the next one is empty or moving,
// so bubbles collapse under output stall.
// Synchronous active-low reset clears the stage valid bits and sets the
// sample format to s16.
module pcm_sample_format_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_word
);
  import psfc_pkg::*;

  localparam int NSTG = 6;

  logic [2:0]      fmt_r;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;
  dec_t            dec_r;
  rnd_t            rnd_r;
  sum_t            sum_r;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fmt_r <= FMT_S16;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  psfc_decode u_decode (
    .clk       (clk),
    .en        (rdy[0]),
    .fmt       (fmt_r),
    .cmd       (in_cmd),
    .data_word (in_data_word),
    .dec_r     (dec_r)
  );

  psfc_mul u_mul (
    .clk    (clk),
    .en_mul (rdy[1]),
    .en_rnd (rdy[2]),
    .dec_r  (dec_r),
    .rnd_r  (rnd_r)
  );

  psfc_align u_align (
    .clk    (clk),
    .en_aln (rdy[3]),
    .en_sum (rdy[4]),
    .rnd_r  (rnd_r),
    .sum_r  (sum_r)
  );

  psfc_round u_round (
    .clk    (clk),
    .en     (rdy[5]),
    .sum_r  (sum_r),
    .word_r (out_result_word)
  );

endmodule
